FILE: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/ssi_pkg.sv
package ssi_pkg;

   localparam int ELEM_WIDTH         = 8;
   localparam int DEFAULT_LIST_DEPTH = 32;

   typedef enum logic [1:0] {
      MODE_LOAD_A  = 2'd0,
      MODE_LOAD_B  = 2'd1,
      MODE_COMPUTE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic [ELEM_WIDTH-1:0] value;
   } ssi_req_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0] element;
      logic                  empty_res;
      logic                  last;
      logic                  overflow;
   } ssi_rsp_type;

   // Per-chain control: insert an element, shift toward the head, or clear.
   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } ssi_ctrl_type;

endpackage

FILE: rtl/sorted_set_intersection.sv
// Load items (list A or B) leave busy low, so a new item may follow straight after.
// Compute item: busy while the merge walk shifts one or both cell chains per cycle, then
// in the finish state; the last result strobes as busy returns low.
// Results strobe for one cycle each on rsp_strobe; the receiver cannot stall.
// Synchronous active-high reset empties both lists and clears the overflow flag.
`include "assert_macros.svh"

module sorted_set_intersection #(
   parameter int LIST_DEPTH = ssi_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ssi_pkg::ssi_req_type req_item,
   output logic                 rsp_strobe,
   output ssi_pkg::ssi_rsp_type rsp_item
);
   import ssi_pkg::*;

   // Each list lives in a chain of cells kept sorted on insertion; cell 0 is the head.
   ssi_ctrl_type          ctrl_a, ctrl_b;
   logic [ELEM_WIDTH-1:0] head_a_value, head_b_value;
   logic                  head_a_valid, head_b_valid;
   logic                  full_a, full_b;

   state_type             state_ff, state_in;
   logic                  dropped_ff, dropped_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [ELEM_WIDTH-1:0] pend_value_ff, pend_value_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   ssi_rsp_type           rsp_ff, rsp_in;

   logic accept, is_load_a, is_load_b, is_compute;
   logic both_valid, match, a_less;

   assign accept     = start && !busy;
   assign is_load_a  = accept && (req_item.mode == MODE_LOAD_A);
   assign is_load_b  = accept && (req_item.mode == MODE_LOAD_B);
   assign is_compute = accept && (req_item.mode == MODE_COMPUTE);

   assign both_valid = head_a_valid && head_b_valid;
   assign match      = both_valid && (head_a_value == head_b_value);
   assign a_less     = head_a_value < head_b_value;

   ssi_chain #(.LIST_DEPTH(LIST_DEPTH)) u_chain_a (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_a),
      .load_value (req_item.value),
      .head_value (head_a_value),
      .head_valid (head_a_valid),
      .full       (full_a)
   );

   ssi_chain #(.LIST_DEPTH(LIST_DEPTH)) u_chain_b (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_b),
      .load_value (req_item.value),
      .head_value (head_b_value),
      .head_valid (head_b_valid),
      .full       (full_b)
   );

   // Next state: walk while both heads hold elements, then emit the final item.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_compute) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (!both_valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      ctrl_a        = '0;
      ctrl_b        = '0;
      dropped_in    = dropped_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      busy          = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            // Insert into a list with room; drop and flag otherwise.
            ctrl_a.load = is_load_a && !full_a;
            ctrl_b.load = is_load_b && !full_b;
            if ((is_load_a && full_a) || (is_load_b && full_b)) begin
               dropped_in = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         ST_MERGE: begin
            // Advance the smaller head, or both on a match.
            ctrl_a.shift = both_valid && (match || a_less);
            ctrl_b.shift = both_valid && !a_less;
            if (match) begin
               // Hold the newest match; release the previous one, not last.
               if (pend_valid_ff) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.element   = pend_value_ff;
                  rsp_in.empty_res = 1'b0;
                  rsp_in.last      = 1'b0;
                  rsp_in.overflow  = dropped_ff;
               end
               pend_valid_in = 1'b1;
               pend_value_in = head_a_value;
            end
         end
         ST_FINISH: begin
            // Emit the held match as last, or the empty marker; empty both lists.
            ctrl_a.clear     = 1'b1;
            ctrl_b.clear     = 1'b1;
            rsp_strobe_in    = 1'b1;
            rsp_in.element   = pend_valid_ff ? pend_value_ff : '0;
            rsp_in.empty_res = !pend_valid_ff;
            rsp_in.last      = 1'b1;
            rsp_in.overflow  = dropped_ff;
            dropped_in       = 1'b0;
            pend_valid_in    = 1'b0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         dropped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dropped_ff    <= dropped_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `ASSERT_NEXT(a_compute_busy, clock, reset, is_compute, busy)
   `ASSERT_NEXT(a_finish_emits_last, clock, reset, state_ff == ST_FINISH,
                rsp_strobe_ff && rsp_ff.last)
   `ASSERT_NEXT(a_finish_empties, clock, reset, state_ff == ST_FINISH,
                !head_a_valid && !head_b_valid)
   `ASSERT_IMPLIES(a_empty_is_last, clock, reset, rsp_strobe_ff && rsp_ff.empty_res,
                   rsp_ff.last && (rsp_ff.element == '0))

endmodule

FILE: rtl/ssi_cell.sv
module ssi_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  ssi_pkg::ssi_ctrl_type            ctrl,
   input  logic [ssi_pkg::ELEM_WIDTH-1:0]   load_value,
   input  logic [ssi_pkg::ELEM_WIDTH-1:0]   prev_value,
   input  logic                             prev_valid,
   input  logic                             prev_gt,
   input  logic [ssi_pkg::ELEM_WIDTH-1:0]   next_value,
   input  logic                             next_valid,
   output logic [ssi_pkg::ELEM_WIDTH-1:0]   value,
   output logic                             valid,
   output logic                             gt
);
   import ssi_pkg::*;

   logic [ELEM_WIDTH-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;

   // New element goes at or before this cell.
   assign gt = !valid_ff || (value_ff > load_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.load) begin
         if (gt && prev_gt) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else if (gt) begin
            value_in = load_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

FILE: rtl/ssi_chain.sv
module ssi_chain #(
   parameter int LIST_DEPTH = ssi_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ssi_pkg::ssi_ctrl_type            ctrl,
   input  logic [ssi_pkg::ELEM_WIDTH-1:0]   load_value,
   output logic [ssi_pkg::ELEM_WIDTH-1:0]   head_value,
   output logic                             head_valid,
   output logic                             full
);
   import ssi_pkg::*;

   logic [ELEM_WIDTH-1:0] value_w [LIST_DEPTH];
   logic                  valid_w [LIST_DEPTH];
   logic                  gt_w    [LIST_DEPTH];

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] prev_value, next_value;
      logic                  prev_valid, prev_gt, next_valid;

      if (i == 0) begin : g_first
         assign prev_value = '0;
         assign prev_valid = 1'b0;
         assign prev_gt    = 1'b0;
      end else begin : g_mid
         assign prev_value = value_w[i-1];
         assign prev_valid = valid_w[i-1];
         assign prev_gt    = gt_w[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_tail
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_body
         assign next_value = value_w[i+1];
         assign next_valid = valid_w[i+1];
      end

      ssi_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load_value (load_value),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_gt    (prev_gt),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (value_w[i]),
         .valid      (valid_w[i]),
         .gt         (gt_w[i])
      );
   end

   assign head_value = value_w[0];
   assign head_valid = valid_w[0];
   assign full       = valid_w[LIST_DEPTH-1];

endmodule
